// ===== sv/eclx_pkg.sv =====
// ============================================================================
// eclx_pkg - shared types and constants of the comment line extractor
// Character codes, the command word that runs from the front to the back end,
// the line store write port and the back end state type.
// ============================================================================
package eclx_pkg;

    // Widest line store the design supports; lengths and store addresses use it
    localparam int CAP_MAX = 62;
    localparam int LEN_W   = $clog2(CAP_MAX + 1);

    // Command queue depth
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    // Character codes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_C     = 8'h63;

    // Marker lines are this long
    localparam logic [LEN_W-1:0] MARK_LEN = LEN_W'(4);

    typedef enum logic {
        CMD_TEXT,
        CMD_LINE
    } t_cmd_kind;

    // One queued piece of output work
    typedef struct packed {
        t_cmd_kind        kind;
        logic             has_slash;  // text: release a held slash first
        logic             has_byte;   // text: emit data
        logic [7:0]       data;
        logic             lead_nl;    // line: newline before the line
        logic             cut;        // line: line was truncated
        logic [LEN_W-1:0] len;        // line: bytes to read from the store
    } t_cmd;

    // Current comment line bookkeeping
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] trim;
        logic             ovf;
    } t_line;

    // Line store write port
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } t_mem_wr;

    // Back end status toward the front end
    typedef struct packed {
        logic line_done;
    } t_back_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TEXT_BYTE,
        BK_LINE_BYTES,
        BK_LINE_NL
    } t_back_state;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

// ===== sv/eclx_front.sv =====
// ============================================================================
// eclx_front - input classifier of the comment line extractor
// Tracks comment and region state, builds the current comment line in the
// back end's line store and queues text and line commands.
// ============================================================================
module eclx_front #(
    parameter int LINE_CAP = 60
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] in_byte
    input  logic                   i_s_tlast,   // in_end
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output eclx_pkg::t_cmd         o_q_cmd,
    output eclx_pkg::t_mem_wr      o_mem_wr,
    input  eclx_pkg::t_back_status i_back_status
);

    localparam logic [eclx_pkg::LEN_W-1:0] CAP_LEN = eclx_pkg::LEN_W'(LINE_CAP);

    eclx_pkg::t_line            r_line, n_line;
    logic                       r_in_comment, n_in_comment;
    logic                       r_exec, n_exec;
    logic                       r_held_slash, n_held_slash;
    logic                       r_held_star, n_held_star;
    logic                       r_emit_any, n_emit_any;
    logic                       r_last_nl, n_last_nl;
    logic                       r_line_busy;
    logic [3:0][7:0]            r_head, n_head;

    logic                       accept;
    logic                       push;
    eclx_pkg::t_cmd             cmd;
    logic                       wr_en;
    logic [eclx_pkg::LEN_W-1:0] wr_addr;
    logic                       handled;
    logic                       closed;
    logic                       text_slash;
    logic                       text_byte;
    logic [7:0]                 b;

    // Byte is kept when it is not a leading blank and the store has room
    function automatic logic stores(input eclx_pkg::t_line s, input logic [7:0] c);
        return !(s.len == '0 && eclx_pkg::is_blank(c)) && (s.len < CAP_LEN);
    endfunction

    function automatic eclx_pkg::t_line add_byte(input eclx_pkg::t_line s,
                                                 input logic [7:0] c);
        eclx_pkg::t_line r;
        r = s;
        if (!(s.len == '0 && eclx_pkg::is_blank(c))) begin
            if (s.len < CAP_LEN) begin
                r.len = s.len + eclx_pkg::LEN_W'(1);
                if (!eclx_pkg::is_blank(c)) begin
                    r.trim = s.len + eclx_pkg::LEN_W'(1);
                end
            end else if (!eclx_pkg::is_blank(c)) begin
                r.ovf = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic is_marker(input eclx_pkg::t_line s,
                                       input logic [3:0][7:0] h,
                                       input logic [7:0] first);
        return !s.ovf && (s.trim == eclx_pkg::MARK_LEN) && (h[0] == first)
            && (h[1] == eclx_pkg::CH_E) && (h[2] == eclx_pkg::CH_X)
            && (h[3] == eclx_pkg::CH_C);
    endfunction

    assign b          = i_s_tdata;
    assign o_s_tready = !r_line_busy && !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Work out the effect of one byte
    always_comb begin
        n_line       = r_line;
        n_in_comment = r_in_comment;
        n_exec       = r_exec;
        n_held_slash = r_held_slash;
        n_held_star  = r_held_star;
        n_emit_any   = r_emit_any;
        n_last_nl    = r_last_nl;
        n_head       = r_head;
        wr_en        = 1'b0;
        wr_addr      = '0;
        push         = 1'b0;
        cmd          = '0;
        handled      = 1'b0;
        closed       = 1'b0;
        text_slash   = 1'b0;
        text_byte    = 1'b0;

        if (!r_in_comment) begin
            // Plain text: release or hold a slash
            if (r_held_slash) begin
                n_held_slash = 1'b0;
                if (b == eclx_pkg::CH_STAR) begin
                    n_in_comment = 1'b1;
                    n_held_star  = 1'b0;
                    n_line       = '0;
                    handled      = 1'b1;
                end else begin
                    text_slash = 1'b1;
                end
            end
            if (!handled) begin
                if (b == eclx_pkg::CH_SLASH && !i_s_tlast) begin
                    n_held_slash = 1'b1;
                end else begin
                    text_byte = 1'b1;
                end
            end
            if (text_slash || text_byte) begin
                push          = 1'b1;
                cmd.kind      = eclx_pkg::CMD_TEXT;
                cmd.has_slash = text_slash;
                cmd.has_byte  = text_byte;
                cmd.data      = b;
                n_emit_any    = 1'b1;
                n_last_nl     = text_byte && (b == eclx_pkg::CH_NL);
            end
        end else begin
            // Comment: a held star either closes or joins the line
            if (r_held_star) begin
                n_held_star = 1'b0;
                if (b == eclx_pkg::CH_SLASH) begin
                    if (is_marker(n_line, n_head, eclx_pkg::CH_DOT)) begin
                        n_exec = 1'b0;
                    end
                    n_in_comment = 1'b0;
                    n_line       = '0;
                    closed       = 1'b1;
                end else begin
                    // star byte was already written when it arrived
                    n_line = add_byte(n_line, eclx_pkg::CH_STAR);
                end
            end
            if (!closed) begin
                if (b == eclx_pkg::CH_STAR) begin
                    n_held_star = 1'b1;
                    if (n_line.len < CAP_LEN) begin
                        wr_en   = 1'b1;
                        wr_addr = n_line.len;
                    end
                end else if (b == eclx_pkg::CH_NL) begin
                    if (is_marker(n_line, n_head, eclx_pkg::CH_AT)) begin
                        n_exec = 1'b1;
                    end else if (is_marker(n_line, n_head, eclx_pkg::CH_DOT)) begin
                        n_exec = 1'b0;
                    end else if (n_exec && n_line.trim != '0) begin
                        push        = 1'b1;
                        cmd.kind    = eclx_pkg::CMD_LINE;
                        cmd.lead_nl = n_emit_any && !n_last_nl;
                        cmd.cut     = n_line.ovf;
                        cmd.len     = n_line.trim;
                        n_emit_any  = 1'b1;
                        n_last_nl   = 1'b1;
                    end
                    n_line = '0;
                end else begin
                    if (stores(n_line, b)) begin
                        wr_en   = 1'b1;
                        wr_addr = n_line.len;
                    end
                    n_line = add_byte(n_line, b);
                end
            end
        end

        // Mirror the first bytes of the line for marker checks
        if (wr_en && wr_addr < eclx_pkg::MARK_LEN) begin
            n_head[wr_addr[1:0]] = b;
        end

        // End of text: finish an open comment line, then return to reset state
        if (i_s_tlast) begin
            if (n_in_comment) begin
                if (n_held_star) begin
                    n_line = add_byte(n_line, eclx_pkg::CH_STAR);
                end
                if (is_marker(n_line, n_head, eclx_pkg::CH_AT)) begin
                    n_exec = 1'b1;
                end else if (is_marker(n_line, n_head, eclx_pkg::CH_DOT)) begin
                    n_exec = 1'b0;
                end else if (n_exec && n_line.trim != '0) begin
                    push        = 1'b1;
                    cmd.kind    = eclx_pkg::CMD_LINE;
                    cmd.lead_nl = n_emit_any && !n_last_nl;
                    cmd.cut     = n_line.ovf;
                    cmd.len     = n_line.trim;
                end
            end
            n_line       = '0;
            n_in_comment = 1'b0;
            n_exec       = 1'b0;
            n_held_slash = 1'b0;
            n_held_star  = 1'b0;
            n_emit_any   = 1'b0;
            n_last_nl    = 1'b0;
        end
    end

    // Commit state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= '0;
            r_in_comment <= 1'b0;
            r_exec       <= 1'b0;
            r_held_slash <= 1'b0;
            r_held_star  <= 1'b0;
            r_emit_any   <= 1'b0;
            r_last_nl    <= 1'b0;
        end else if (accept) begin
            r_line       <= n_line;
            r_in_comment <= n_in_comment;
            r_exec       <= n_exec;
            r_held_slash <= n_held_slash;
            r_held_star  <= n_held_star;
            r_emit_any   <= n_emit_any;
            r_last_nl    <= n_last_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head <= n_head;
        end
    end

    // Hold input while a queued line still reads the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_busy <= 1'b0;
        end else if (accept && push && cmd.kind == eclx_pkg::CMD_LINE) begin
            r_line_busy <= 1'b1;
        end else if (i_back_status.line_done) begin
            r_line_busy <= 1'b0;
        end
    end

    assign o_q_push      = accept && push;
    assign o_q_cmd       = cmd;
    assign o_mem_wr.en   = accept && wr_en;
    assign o_mem_wr.addr = wr_addr;
    assign o_mem_wr.data = b;

    // The final byte of a text leaves no comment, slash or region open
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tlast) |=> (!r_in_comment && !r_held_slash && !r_exec))
        else $error("state not cleared after final byte");

endmodule

// ===== sv/eclx_queue.sv =====
// ============================================================================
// eclx_queue - command queue between front and back end
// Small register FIFO of output commands.
// ============================================================================
module eclx_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  eclx_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output eclx_pkg::t_cmd o_head
);

    eclx_pkg::t_cmd              r_slot [eclx_pkg::Q_DEPTH];
    logic [eclx_pkg::QP_W-1:0]   r_wp;
    logic [eclx_pkg::QP_W-1:0]   r_rp;
    logic [eclx_pkg::QP_W:0]     r_count;

    assign o_full  = (r_count == (eclx_pkg::QP_W + 1)'(eclx_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rp];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full command queue");

endmodule

// ===== sv/eclx_back.sv =====
// ============================================================================
// eclx_back - output sequencer of the comment line extractor
// Holds the line store, carries out queued text and line commands and drives
// the output register.
// ============================================================================
module eclx_back #(
    parameter int LINE_CAP = 60
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  eclx_pkg::t_cmd         i_q_head,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    input  eclx_pkg::t_mem_wr      i_mem_wr,
    output eclx_pkg::t_back_status o_status,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,   // [7:0] out_byte
    output logic                   o_m_tlast,   // out_last
    output logic [0:0]             o_m_tuser    // [0] out_truncated
);

    localparam int AW = $clog2(LINE_CAP);

    logic [7:0]                 r_line_store [LINE_CAP];
    logic [7:0]                 r_rd_data;

    eclx_pkg::t_back_state      r_state, n_state;
    logic [AW-1:0]              r_idx, n_idx;
    logic [eclx_pkg::LEN_W-1:0] r_len, n_len;
    logic                       r_cut, n_cut;
    logic [7:0]                 r_data, n_data;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;
    logic                       r_out_cut;

    logic                       can_load;
    logic                       last_idx;
    logic                       load;
    logic [7:0]                 ld_byte;
    logic                       ld_last;
    logic                       ld_cut;
    logic                       pop;
    logic                       line_done;

    // Line store: written by the front end, read one byte ahead of use
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_line_store[i_mem_wr.addr[AW-1:0]] <= i_mem_wr.data;
        end
        r_rd_data <= r_line_store[n_idx];
    end

    assign can_load = !r_out_valid || i_m_tready;
    assign last_idx = (eclx_pkg::LEN_W'(r_idx) + eclx_pkg::LEN_W'(1)) == r_len;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            eclx_pkg::BK_IDLE: begin
                if (!i_q_empty && can_load) begin
                    if (i_q_head.kind == eclx_pkg::CMD_LINE) begin
                        n_state = eclx_pkg::BK_LINE_BYTES;
                    end else if (i_q_head.has_slash && i_q_head.has_byte) begin
                        n_state = eclx_pkg::BK_TEXT_BYTE;
                    end
                end
            end
            eclx_pkg::BK_TEXT_BYTE: begin
                if (can_load) begin
                    n_state = eclx_pkg::BK_IDLE;
                end
            end
            eclx_pkg::BK_LINE_BYTES: begin
                if (can_load && last_idx) begin
                    n_state = eclx_pkg::BK_LINE_NL;
                end
            end
            eclx_pkg::BK_LINE_NL: begin
                if (can_load) begin
                    n_state = eclx_pkg::BK_IDLE;
                end
            end
            default: n_state = eclx_pkg::BK_IDLE;
        endcase
    end

    // Outputs of each state
    always_comb begin
        pop       = 1'b0;
        load      = 1'b0;
        ld_byte   = r_rd_data;
        ld_last   = 1'b0;
        ld_cut    = 1'b0;
        line_done = 1'b0;
        n_idx     = r_idx;
        n_len     = r_len;
        n_cut     = r_cut;
        n_data    = r_data;
        case (r_state)
            eclx_pkg::BK_IDLE: begin
                if (!i_q_empty && can_load) begin
                    pop    = 1'b1;
                    n_data = i_q_head.data;
                    n_len  = i_q_head.len;
                    n_cut  = i_q_head.cut;
                    n_idx  = '0;
                    if (i_q_head.kind == eclx_pkg::CMD_TEXT) begin
                        load = 1'b1;
                        if (i_q_head.has_slash) begin
                            ld_byte = eclx_pkg::CH_SLASH;
                            ld_last = !i_q_head.has_byte;
                        end else begin
                            ld_byte = i_q_head.data;
                            ld_last = 1'b1;
                        end
                    end else if (i_q_head.lead_nl) begin
                        load    = 1'b1;
                        ld_byte = eclx_pkg::CH_NL;
                        ld_cut  = i_q_head.cut;
                    end
                end
            end
            eclx_pkg::BK_TEXT_BYTE: begin
                if (can_load) begin
                    load    = 1'b1;
                    ld_byte = r_data;
                    ld_last = 1'b1;
                end
            end
            eclx_pkg::BK_LINE_BYTES: begin
                if (can_load) begin
                    load    = 1'b1;
                    ld_byte = r_rd_data;
                    ld_cut  = r_cut;
                    if (!last_idx) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            eclx_pkg::BK_LINE_NL: begin
                if (can_load) begin
                    load      = 1'b1;
                    ld_byte   = eclx_pkg::CH_NL;
                    ld_last   = 1'b1;
                    ld_cut    = r_cut;
                    line_done = 1'b1;
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eclx_pkg::BK_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_cut  <= n_cut;
        r_data <= n_data;
    end

    // Output register: load a byte or drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= ld_byte;
            r_out_last <= ld_last;
            r_out_cut  <= ld_cut;
        end
    end

    assign o_q_pop            = pop;
    assign o_status.line_done = line_done;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out_byte;
    assign o_m_tlast          = r_out_last;
    assign o_m_tuser          = r_out_cut;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (!i_q_empty && r_state == eclx_pkg::BK_IDLE))
        else $error("command popped outside idle or from empty queue");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_done |=> (r_out_valid && r_out_last))
        else $error("line finished without a final newline marked last");

    a_no_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eclx_pkg::BK_LINE_BYTES) |-> !i_mem_wr.en)
        else $error("line store written while a line is read out");

endmodule

// ===== sv/exec_comment_line_extractor.sv =====
// ============================================================================
// exec_comment_line_extractor - executable comment line extractor
// Passes source text outside block comments and emits the non-empty comment
// lines found between "@exc" and ".exc" marker lines.
// ============================================================================
// The input accepts a new byte while the command queue has room and no comment
// line is read out: plain text and comment bytes are classified by the front end
// and text goes out through a short command queue and the output register, so
// input keeps flowing while a result waits. A comment line that is emitted
// occupies the single read port of the line store: from the byte that ends it,
// input stalls until the line has been read out (the command pop, which also
// sends an optional leading newline, then the bytes, then the closing newline),
// and longer while earlier text is still queued or the output stalls. Lines are
// kept up to LINE_CAP bytes after leading blanks; longer lines are cut and
// every byte of the emitted line, newlines included, carries the truncation
// flag in tuser. No clearing pass runs after reset; the block accepts input
// at once.
module exec_comment_line_extractor #(
    parameter int LINE_CAP = 60
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // out_last
    output logic [0:0] o_m_tuser    // [0] out_truncated
);

    logic                   q_full;
    logic                   q_empty;
    logic                   q_push;
    logic                   q_pop;
    eclx_pkg::t_cmd         q_in;
    eclx_pkg::t_cmd         q_head;
    eclx_pkg::t_mem_wr      mem_wr;
    eclx_pkg::t_back_status back_status;

    eclx_front #(
        .LINE_CAP (LINE_CAP)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in),
        .o_mem_wr      (mem_wr),
        .i_back_status (back_status)
    );

    eclx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    eclx_back #(
        .LINE_CAP (LINE_CAP)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_head   (q_head),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_mem_wr   (mem_wr),
        .o_status   (back_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== bench/exec_comment_line_extractor_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// exec_comment_line_extractor_tb - self-checking bench of the line extractor
// Streams a directed table of source bytes, then random source texts made of
// plain text, block comments with marker lines, content lines (a few cut at
// the line limit) and noise. Every accepted result is compared field by field
// with the bytes given in its directed row or with a model of the extractor.
// ============================================================================
module exec_comment_line_extractor_tb;

    localparam int LINE_CAP  = 60;
    localparam int DIR_N     = 27;
    localparam int RAND_N    = 210;
    localparam int CYC_LIMIT = 500000;
    localparam int IDLE_PCT  = 30;

    // How the expected results of a stimulus row are obtained
    typedef enum logic [1:0] {
        KN_PRED,    // from the software model
        KN_NONE,    // no result at all
        KN_ONE,     // one byte: k0
        KN_TWO      // two bytes: k0 then k1
    } t_known;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
        t_known     kn;
        logic [7:0] k0;
        logic [7:0] k1;
    } t_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       cut;
    } t_out_byte;

    // Directed rows: pass-through extremes, slash handling, one marked region
    localparam t_row DIR_TAB [DIR_N] = '{
        '{8'h00,              1'b0, KN_ONE,  8'h00,              8'h00},
        '{8'hFF,              1'b0, KN_ONE,  8'hFF,              8'h00},
        '{eclx_pkg::CH_SLASH, 1'b0, KN_NONE, 8'h00,              8'h00},
        '{eclx_pkg::CH_X,     1'b0, KN_TWO,  eclx_pkg::CH_SLASH, eclx_pkg::CH_X},
        '{eclx_pkg::CH_SLASH, 1'b1, KN_ONE,  eclx_pkg::CH_SLASH, 8'h00},
        '{eclx_pkg::CH_SLASH, 1'b0, KN_NONE, 8'h00,              8'h00},
        '{eclx_pkg::CH_STAR,  1'b0, KN_NONE, 8'h00,              8'h00},
        '{eclx_pkg::CH_TAB,   1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_AT,    1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_E,     1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_X,     1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_C,     1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_SPACE, 1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_NL,    1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_SPACE, 1'b0, KN_PRED, 8'h00,              8'h00},
        '{8'h68,              1'b0, KN_PRED, 8'h00,              8'h00},
        '{8'h69,              1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_STAR,  1'b0, KN_PRED, 8'h00,              8'h00},
        '{8'h71,              1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_NL,    1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_DOT,   1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_E,     1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_X,     1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_C,     1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_STAR,  1'b0, KN_PRED, 8'h00,              8'h00},
        '{eclx_pkg::CH_SLASH, 1'b0, KN_PRED, 8'h00,              8'h00},
        '{8'h5A,              1'b1, KN_ONE,  8'h5A,              8'h00}
    };

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [0:0] o_m_tuser;

    exec_comment_line_extractor #(
        .LINE_CAP(LINE_CAP)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),   // [7:0] in_byte
        .i_s_tlast (i_s_tlast),   // in_end
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),   // [7:0] out_byte
        .o_m_tlast (o_m_tlast),   // out_last
        .o_m_tuser (o_m_tuser)    // [0] out_truncated
    );

    always #1 i_clk = ~i_clk;

    t_row      src_q [$];
    t_out_byte due_q [$];
    t_out_byte step_q [$];
    int        n_acc   = 0;
    int        n_bad   = 0;
    int        n_cyc   = 0;
    logic      no_idle = 1'b0;

    // Extractor model state
    logic [7:0] ln_buf [LINE_CAP];
    logic [5:0] ln_len     = '0;
    logic [5:0] ln_trim    = '0;
    logic       ln_ovf     = 1'b0;
    logic       in_cmt     = 1'b0;
    logic       in_exec    = 1'b0;
    logic       slash_held = 1'b0;
    logic       star_held  = 1'b0;
    logic       any_out    = 1'b0;
    logic       last_nl    = 1'b0;

    task automatic put_out(input logic [7:0] b, input logic cut);
        step_q.push_back(t_out_byte'{b, 1'b0, cut});
        any_out = 1'b1;
        last_nl = (b == eclx_pkg::CH_NL);
    endtask

    task automatic line_clear();
        ln_len  = '0;
        ln_trim = '0;
        ln_ovf  = 1'b0;
    endtask

    // Append to the current comment line; drop leading blanks and overflow
    task automatic line_add(input logic [7:0] b);
        logic bl;
        bl = (b == eclx_pkg::CH_SPACE) || (b == eclx_pkg::CH_TAB);
        if (ln_len == 0 && bl)
            return;
        if (ln_len < LINE_CAP) begin
            ln_buf[ln_len] = b;
            ln_len = ln_len + 1'b1;
            if (!bl)
                ln_trim = ln_len;
        end else if (!bl) begin
            ln_ovf = 1'b1;
        end
    endtask

    // Both markers end in "exc"; c0 picks the opening or the closing one
    function automatic logic line_is_marker(input logic [7:0] c0);
        return !ln_ovf && ln_trim == 4 && ln_buf[0] == c0
            && ln_buf[1] == eclx_pkg::CH_E && ln_buf[2] == eclx_pkg::CH_X
            && ln_buf[3] == eclx_pkg::CH_C;
    endfunction

    task automatic line_finish();
        if (line_is_marker(eclx_pkg::CH_AT)) begin
            in_exec = 1'b1;
        end else if (line_is_marker(eclx_pkg::CH_DOT)) begin
            in_exec = 1'b0;
        end else if (in_exec && ln_trim > 0) begin
            if (any_out && !last_nl)
                put_out(eclx_pkg::CH_NL, ln_ovf);
            for (int k = 0; k < ln_trim; k++)
                put_out(ln_buf[k], ln_ovf);
            put_out(eclx_pkg::CH_NL, ln_ovf);
        end
        line_clear();
    endtask

    // Advance the model by one source byte; results land in step_q
    task automatic extract_byte(input logic [7:0] b, input logic e);
        logic taken;
        logic closed;
        step_q.delete();
        if (!in_cmt) begin
            taken = 1'b0;
            if (slash_held) begin
                slash_held = 1'b0;
                if (b == eclx_pkg::CH_STAR) begin
                    in_cmt    = 1'b1;
                    star_held = 1'b0;
                    line_clear();
                    taken     = 1'b1;
                end else begin
                    put_out(eclx_pkg::CH_SLASH, 1'b0);
                end
            end
            if (!taken) begin
                if (b == eclx_pkg::CH_SLASH && !e)
                    slash_held = 1'b1;
                else
                    put_out(b, 1'b0);
            end
        end else begin
            closed = 1'b0;
            if (star_held) begin
                star_held = 1'b0;
                if (b == eclx_pkg::CH_SLASH) begin
                    if (line_is_marker(eclx_pkg::CH_DOT))
                        in_exec = 1'b0;
                    in_cmt = 1'b0;
                    line_clear();
                    closed = 1'b1;
                end else begin
                    line_add(eclx_pkg::CH_STAR);
                end
            end
            if (!closed) begin
                if (b == eclx_pkg::CH_STAR)
                    star_held = 1'b1;
                else if (b == eclx_pkg::CH_NL)
                    line_finish();
                else
                    line_add(b);
            end
        end
        // End of text: flush an open comment line, then back to reset state
        if (e) begin
            if (in_cmt) begin
                if (star_held)
                    line_add(eclx_pkg::CH_STAR);
                line_finish();
            end
            line_clear();
            in_cmt     = 1'b0;
            in_exec    = 1'b0;
            slash_held = 1'b0;
            star_held  = 1'b0;
            any_out    = 1'b0;
            last_nl    = 1'b0;
        end
    endtask

    task automatic push_src(input logic [7:0] b, input logic e);
        src_q.push_back(t_row'{b, e, KN_PRED, 8'h00, 8'h00});
    endtask

    task automatic push_blanks();
        repeat ($urandom_range(0, 2))
            push_src($urandom_range(0, 1) ? eclx_pkg::CH_SPACE : eclx_pkg::CH_TAB, 1'b0);
    endtask

    // Marker line with random blanks; now and then one character is broken
    task automatic push_marker(input logic [7:0] c0);
        logic [7:0] mk [4];
        int         bad;
        mk[0] = c0;
        mk[1] = eclx_pkg::CH_E;
        mk[2] = eclx_pkg::CH_X;
        mk[3] = eclx_pkg::CH_C;
        bad = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
        push_blanks();
        for (int k = 0; k < 4; k++)
            push_src((k == bad) ? 8'($urandom_range(0, 255)) : mk[k], 1'b0);
        push_blanks();
    endtask

    // Predict each input transfer and queue what the output must carry
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            extract_byte(i_s_tdata, i_s_tlast);
            case (src_q[n_acc].kn)
                KN_PRED: begin
                    for (int k = 0; k < step_q.size(); k++)
                        due_q.push_back(t_out_byte'{step_q[k].data,
                            k == step_q.size() - 1, step_q[k].cut});
                end
                KN_ONE: begin
                    due_q.push_back(t_out_byte'{src_q[n_acc].k0, 1'b1, 1'b0});
                end
                KN_TWO: begin
                    due_q.push_back(t_out_byte'{src_q[n_acc].k0, 1'b0, 1'b0});
                    due_q.push_back(t_out_byte'{src_q[n_acc].k1, 1'b1, 1'b0});
                end
                default: ;
            endcase
            n_acc <= n_acc + 1;
        end
    end

    // Compare each output transfer with the oldest due byte
    t_out_byte got_want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_q.size() == 0) begin
                $error("unexpected result: out_byte %h", o_m_tdata);
                n_bad++;
            end else begin
                got_want = due_q.pop_front();
                if (o_m_tdata !== got_want.data) begin
                    $error("out_byte: expected %h, actual %h", got_want.data, o_m_tdata);
                    n_bad++;
                end
                if (o_m_tlast !== got_want.last) begin
                    $error("out_last: expected %b, actual %b", got_want.last, o_m_tlast);
                    n_bad++;
                end
                if (o_m_tuser[0] !== got_want.cut) begin
                    $error("out_truncated: expected %b, actual %b",
                           got_want.cut, o_m_tuser[0]);
                    n_bad++;
                end
            end
        end
    end

    // Receiver stalls at random outside the steady stretch
    always @(posedge i_clk) begin
        if (no_idle)
            i_m_tready <= 1'b1;
        else
            i_m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hard stop on a hung run
    always @(posedge i_clk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc == CYC_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int         n_cmt;
        int         n_ln;
        int         len;
        int         r;
        logic [7:0] c;
        logic       unclosed;

        for (int k = 0; k < LINE_CAP; k++)
            ln_buf[k] = 8'h00;

        // Build the stimulus: the directed table, then random source texts
        for (int k = 0; k < DIR_N; k++)
            src_q.push_back(DIR_TAB[k]);
        while (src_q.size() < DIR_N + RAND_N) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 6))
                    push_src(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end else begin
                unclosed = 1'b0;
                n_cmt = $urandom_range(1, 3);
                for (int m = 0; m < n_cmt && !unclosed; m++) begin
                    repeat ($urandom_range(0, 4))
                        push_src(8'($urandom_range(0, 255)), 1'b0);
                    push_src(eclx_pkg::CH_SLASH, 1'b0);
                    push_src(eclx_pkg::CH_STAR, 1'b0);
                    if ($urandom_range(0, 99) < 80) begin
                        push_marker(eclx_pkg::CH_AT);
                        push_src(eclx_pkg::CH_NL, 1'b0);
                    end
                    n_ln = $urandom_range(1, 3);
                    repeat (n_ln) begin
                        len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 70)
                                                          : $urandom_range(0, 10);
                        push_blanks();
                        repeat (len) begin
                            r = $urandom_range(0, 99);
                            if (r < 80)
                                c = 8'($urandom_range(8'h21, 8'h7E));
                            else if (r < 92)
                                c = $urandom_range(0, 1) ? eclx_pkg::CH_SPACE
                                                         : eclx_pkg::CH_TAB;
                            else
                                c = 8'($urandom_range(0, 255));
                            push_src(c, 1'b0);
                        end
                        push_blanks();
                        push_src(eclx_pkg::CH_NL, 1'b0);
                    end
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        // closing marker right before the star-slash
                        push_marker(eclx_pkg::CH_DOT);
                        push_src(eclx_pkg::CH_STAR, 1'b0);
                        push_src(eclx_pkg::CH_SLASH, 1'b0);
                    end else if (r < 80) begin
                        push_src(eclx_pkg::CH_STAR, 1'b0);
                        push_src(eclx_pkg::CH_SLASH, 1'b0);
                    end else begin
                        // text ends inside the comment, sometimes on a star
                        push_src($urandom_range(0, 2) == 0
                                     ? eclx_pkg::CH_STAR
                                     : 8'($urandom_range(8'h21, 8'h7E)),
                                 1'b1);
                        unclosed = 1'b1;
                    end
                end
                if (!unclosed) begin
                    repeat ($urandom_range(0, 3))
                        push_src(8'($urandom_range(0, 255)), 1'b0);
                    push_src(8'($urandom_range(0, 255)), 1'b1);
                end
            end
        end

        // Reset
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Drive source bytes with random gaps
        for (int i = 0; i < src_q.size(); i++) begin
            no_idle <= (i >= DIR_N + 100) && (i < DIR_N + 180);
            if (i == DIR_N || i == DIR_N + 200) begin
                // hold off until the output has caught up
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (due_q.size() != 0) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= src_q[i].b;
            i_s_tlast  <= src_q[i].e;
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b0;
        no_idle    <= 1'b0;

        // Drain, then watch for stray results
        @(posedge i_clk);
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
